[rtl/stvg_pkg.sv]
// Shared types, constants and the ring trigonometry helper of the stream tube
// vertex generator. No dependencies; every other file of the block uses it.

package stvg_pkg;

   localparam int TESSELATION_DEF = 16;
   localparam int MAX_SAMPLES_DEF = 4096;
   localparam int QUEUE_DEPTH_DEF = 2;

   localparam logic [30:0] RADIUS_RESET = 31'd65536;
   localparam logic signed [31:0] ONE_Q30 = 32'sh4000_0000;
   localparam logic [63:0] PI_HALF_Q30 = 64'd1686629713;
   localparam logic signed [33:0] HELPER_EPS = 34'sd128;

   typedef struct packed {
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
      logic signed [31:0] pos_z;
      logic signed [31:0] vel_x;
      logic signed [31:0] vel_y;
      logic signed [31:0] vel_z;
      logic first_sample;
      logic last_sample;
   } req_type;

   typedef struct packed {
      logic signed [31:0] vert_x;
      logic signed [31:0] vert_y;
      logic signed [31:0] vert_z;
      logic signed [31:0] color_r;
      logic signed [31:0] color_g;
      logic signed [31:0] color_b;
      logic [15:0] quad_index_a;
      logic [15:0] quad_index_b;
      logic quad_valid;
      logic ring_end;
   } rsp_type;

   typedef struct packed {
      req_type req;
      logic [15:0] base;
   } job_type;

   typedef struct packed {
      logic signed [62:0] x;
      logic signed [62:0] y;
      logic signed [62:0] z;
   } norm_in_type;

   typedef struct packed {
      logic signed [31:0] x;
      logic signed [31:0] y;
      logic signed [31:0] z;
   } norm_out_type;

   typedef struct packed {
      logic done;
      logic nonzero;
   } norm_stat_type;

   // Returns {cos, sin} in Q2.30 of an in-quadrant angle b, both clamped to [0, 1].
   function automatic logic [63:0] taylor_cs(input logic [63:0] b);
      logic [63:0] x2;
      logic [63:0] tc;
      logic [63:0] ts;
      logic signed [63:0] c;
      logic signed [63:0] s;
      logic [31:0] cc;
      logic [31:0] ss;
      x2 = (b * b) >> 30;
      tc = 64'(ONE_Q30);
      ts = b;
      c = 64'(ONE_Q30);
      s = signed'(b);
      tc = ((tc * x2) >> 30) / 64'd2;   ts = ((ts * x2) >> 30) / 64'd6;
      c = c - signed'(tc);              s = s - signed'(ts);
      tc = ((tc * x2) >> 30) / 64'd12;  ts = ((ts * x2) >> 30) / 64'd20;
      c = c + signed'(tc);              s = s + signed'(ts);
      tc = ((tc * x2) >> 30) / 64'd30;  ts = ((ts * x2) >> 30) / 64'd42;
      c = c - signed'(tc);              s = s - signed'(ts);
      tc = ((tc * x2) >> 30) / 64'd56;  ts = ((ts * x2) >> 30) / 64'd72;
      c = c + signed'(tc);              s = s + signed'(ts);
      tc = ((tc * x2) >> 30) / 64'd90;  ts = ((ts * x2) >> 30) / 64'd110;
      c = c - signed'(tc);              s = s - signed'(ts);
      tc = ((tc * x2) >> 30) / 64'd132; ts = ((ts * x2) >> 30) / 64'd156;
      c = c + signed'(tc);              s = s + signed'(ts);
      tc = ((tc * x2) >> 30) / 64'd182; ts = ((ts * x2) >> 30) / 64'd210;
      c = c - signed'(tc);              s = s - signed'(ts);
      tc = ((tc * x2) >> 30) / 64'd240; ts = ((ts * x2) >> 30) / 64'd272;
      c = c + signed'(tc);              s = s + signed'(ts);
      tc = ((tc * x2) >> 30) / 64'd306; ts = ((ts * x2) >> 30) / 64'd342;
      c = c - signed'(tc);              s = s - signed'(ts);
      if (c < 0) begin
         c = 0;
      end
      if (c > 64'(ONE_Q30)) begin
         c = 64'(ONE_Q30);
      end
      if (s < 0) begin
         s = 0;
      end
      if (s > 64'(ONE_Q30)) begin
         s = 64'(ONE_Q30);
      end
      cc = 32'(c);
      ss = 32'(s);
      return {cc, ss};
   endfunction

endpackage

[rtl/stream_tube_vertex_generator.sv]
// Top level of the stream tube vertex generator: configuration register and
// the front, queue and back parts. Depends on stvg_pkg and all stvg_ modules.
//
// Samples enter through push/full with req_data; each accepted sample that is
// kept yields TESSELATION ring vertices, read through empty/pop on rsp_data,
// oldest first, ring_end set on the last vertex of a ring. The tube radius is
// written through csr_valid/csr_ready/csr_data, which is always ready.
// Each sample costs three normalizations (one bit a cycle in the scaling,
// square root and divider loops; a zero velocity skips the loops in the
// first), a cross product and a run of products per vertex on the shared
// multiplier, and each ring's vertices are emitted after its frame is set up.
// The front accepts further samples into a short queue while the back works.
// A stalled receiver holds the current vertex and stops the back after the
// next vertex is ready; the queue then fills and full rises.
// Reset restores a radius of 1.0, clears the ring count and empties the queue and the result register.

module stream_tube_vertex_generator #(
   parameter int TESSELATION = stvg_pkg::TESSELATION_DEF,
   parameter int MAX_SAMPLES = stvg_pkg::MAX_SAMPLES_DEF,
   parameter int QUEUE_DEPTH = stvg_pkg::QUEUE_DEPTH_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   output logic              full,
   input  stvg_pkg::req_type req_data,
   output logic              empty,
   input  logic              pop,
   output stvg_pkg::rsp_type rsp_data,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [30:0]       csr_data
);

   logic [30:0]       radius_ff;
   logic              q_push;
   logic              q_full;
   logic              q_pop;
   logic              q_empty;
   stvg_pkg::job_type q_wdata;
   stvg_pkg::job_type q_rdata;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         radius_ff <= stvg_pkg::RADIUS_RESET;
      end else if (csr_valid && csr_ready) begin
         radius_ff <= csr_data;
      end
   end

   stvg_front #(
      .TESSELATION (TESSELATION),
      .MAX_SAMPLES (MAX_SAMPLES)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .full     (full),
      .req_data (req_data),
      .radius   (radius_ff),
      .q_full   (q_full),
      .q_push   (q_push),
      .q_data   (q_wdata)
   );

   stvg_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock (clock),
      .reset (reset),
      .push  (q_push),
      .wdata (q_wdata),
      .full  (q_full),
      .pop   (q_pop),
      .rdata (q_rdata),
      .empty (q_empty)
   );

   stvg_back #(
      .TESSELATION (TESSELATION)
   ) u_back (
      .clock    (clock),
      .reset    (reset),
      .radius   (radius_ff),
      .q_empty  (q_empty),
      .q_pop    (q_pop),
      .q_data   (q_rdata),
      .pop      (pop),
      .empty    (empty),
      .rsp_data (rsp_data)
   );

   a_reset_empty: assert property (@(posedge clock) reset |=> empty)
      else $error("result side not empty after reset");

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      !(q_push && q_full))
      else $error("job pushed into a full queue");

   a_quad_step: assert property (@(posedge clock) disable iff (reset)
      (!empty && rsp_data.quad_valid && !rsp_data.ring_end)
      |-> (rsp_data.quad_index_b == rsp_data.quad_index_a + 16'd1))
      else $error("quad corner indices not adjacent");

   a_last_no_quad: assert property (@(posedge clock) disable iff (reset)
      (!empty && !rsp_data.quad_valid)
      |-> (rsp_data.quad_index_a == 16'd0 && rsp_data.quad_index_b == 16'd0))
      else $error("indices present on a ring without quads");

endmodule

[rtl/stvg_front.sv]
// Input side of the stream tube vertex generator: ring counting, sample drop
// and zero-radius filtering. Depends on stvg_pkg; feeds stvg_queue.

module stvg_front #(
   parameter int TESSELATION = stvg_pkg::TESSELATION_DEF,
   parameter int MAX_SAMPLES = stvg_pkg::MAX_SAMPLES_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   output logic              full,
   input  stvg_pkg::req_type req_data,
   input  logic [30:0]       radius,
   input  logic              q_full,
   output logic              q_push,
   output stvg_pkg::job_type q_data
);

   localparam int CW = $clog2(MAX_SAMPLES + 1);

   logic [CW-1:0] count_ff;
   logic [CW-1:0] count_in;
   logic [CW-1:0] count_eff;
   logic          accept;
   logic          keep;

   always_comb begin
      accept    = push && !q_full;
      count_eff = req_data.first_sample ? '0 : count_ff;
      keep      = count_eff < CW'(MAX_SAMPLES);
      count_in  = count_ff;
      if (accept) begin
         count_in = keep ? count_eff + 1'b1 : count_eff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   assign full        = q_full;
   assign q_push      = accept && keep && (radius != '0);
   assign q_data.req  = req_data;
   assign q_data.base = 16'(32'(count_eff) * 32'(TESSELATION));

endmodule

[rtl/stvg_queue.sv]
// Short job queue between the front and back of the stream tube vertex
// generator. Depends on stvg_pkg for the job type.

module stvg_queue #(
   parameter int DEPTH = stvg_pkg::QUEUE_DEPTH_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  stvg_pkg::job_type wdata,
   output logic              full,
   input  logic              pop,
   output stvg_pkg::job_type rdata,
   output logic              empty
);

   localparam int AW = $clog2(DEPTH);
   localparam int NW = $clog2(DEPTH + 1);

   stvg_pkg::job_type entry_ff [DEPTH];
   logic [AW-1:0] wptr_ff;
   logic [AW-1:0] rptr_ff;
   logic [NW-1:0] count_ff;
   logic          do_push;
   logic          do_pop;

   assign full    = count_ff == NW'(DEPTH);
   assign empty   = count_ff == '0;
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign rdata   = entry_ff[rptr_ff];

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wptr_ff] <= wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff  <= '0;
         rptr_ff  <= '0;
         count_ff <= '0;
      end else begin
         if (do_push) begin
            wptr_ff <= (wptr_ff == AW'(DEPTH - 1)) ? '0 : wptr_ff + 1'b1;
         end
         if (do_pop) begin
            rptr_ff <= (rptr_ff == AW'(DEPTH - 1)) ? '0 : rptr_ff + 1'b1;
         end
         if (do_push && !do_pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (do_pop && !do_push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

endmodule

[rtl/stvg_norm.sv]
// Iterative vector normalizer: power-of-two scaling, sum of squares, a bit-pair
// square root and three restoring dividers. Depends on stvg_pkg.

module stvg_norm (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  stvg_pkg::norm_in_type  vec_in,
   output stvg_pkg::norm_out_type vec_out,
   output stvg_pkg::norm_stat_type stat
);

   localparam logic [2:0] N_IDLE  = 3'd0;
   localparam logic [2:0] N_SCALE = 3'd1;
   localparam logic [2:0] N_SQ    = 3'd2;
   localparam logic [2:0] N_SQRT  = 3'd3;
   localparam logic [2:0] N_DIV   = 3'd4;

   logic [2:0]  state_ff;
   logic [4:0]  cnt_ff;
   logic [61:0] u_ff [3];
   logic [61:0] m_ff;
   logic        neg_ff [3];
   logic [61:0] sq_ff;
   logic [63:0] acc_ff;
   logic [63:0] s_ff;
   logic [34:0] rem_ff;
   logic [31:0] root_ff;
   logic [31:0] drem_ff [3];
   logic [30:0] lo_ff [3];
   logic [30:0] q_ff [3];
   logic        done_ff;
   logic        nz_ff;
   stvg_pkg::norm_out_type out_ff;

   logic [61:0] mag_in [3];
   logic [61:0] max_in;
   logic [61:0] sq_op;
   logic [34:0] rem_try;
   logic [34:0] trial;
   logic [32:0] r2 [3];
   logic [31:0] drem_in [3];
   logic [30:0] q_in [3];

   always_comb begin
      mag_in[0] = 62'(vec_in.x < 0 ? -vec_in.x : vec_in.x);
      mag_in[1] = 62'(vec_in.y < 0 ? -vec_in.y : vec_in.y);
      mag_in[2] = 62'(vec_in.z < 0 ? -vec_in.z : vec_in.z);
      max_in = mag_in[0];
      if (mag_in[1] > max_in) begin
         max_in = mag_in[1];
      end
      if (mag_in[2] > max_in) begin
         max_in = mag_in[2];
      end
      unique case (cnt_ff[1:0])
         2'd0: sq_op = u_ff[0];
         2'd1: sq_op = u_ff[1];
         2'd2: sq_op = u_ff[2];
         default: sq_op = '0;
      endcase
      rem_try = {rem_ff[32:0], s_ff[63:62]};
      trial   = {1'b0, root_ff, 2'b01};
      for (int c = 0; c < 3; c++) begin
         r2[c] = {drem_ff[c], lo_ff[c][30]};
         if (r2[c] >= {1'b0, root_ff}) begin
            drem_in[c] = 32'(r2[c] - {1'b0, root_ff});
            q_in[c]    = {q_ff[c][29:0], 1'b1};
         end else begin
            drem_in[c] = r2[c][31:0];
            q_in[c]    = {q_ff[c][29:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= N_IDLE;
         done_ff  <= 1'b0;
         cnt_ff   <= '0;
      end else begin
         done_ff <= ((state_ff == N_IDLE) && start && (max_in == '0))
                    || ((state_ff == N_DIV) && (cnt_ff == 5'd30));
         unique case (state_ff)
            N_IDLE: begin
               if (start) begin
                  u_ff      <= mag_in;
                  m_ff      <= max_in;
                  neg_ff[0] <= vec_in.x < 0;
                  neg_ff[1] <= vec_in.y < 0;
                  neg_ff[2] <= vec_in.z < 0;
                  if (max_in == '0) begin
                     out_ff  <= '0;
                     nz_ff   <= 1'b0;
                  end else begin
                     state_ff <= N_SCALE;
                  end
               end
            end
            N_SCALE: begin
               if (m_ff[61:31] != '0) begin
                  m_ff <= m_ff >> 1;
                  for (int c = 0; c < 3; c++) begin
                     u_ff[c] <= u_ff[c] >> 1;
                  end
               end else if (!m_ff[30]) begin
                  m_ff <= m_ff << 1;
                  for (int c = 0; c < 3; c++) begin
                     u_ff[c] <= u_ff[c] << 1;
                  end
               end else begin
                  cnt_ff   <= '0;
                  acc_ff   <= '0;
                  state_ff <= N_SQ;
               end
            end
            N_SQ: begin
               sq_ff <= 62'(62'(sq_op[30:0]) * 62'(sq_op[30:0]));
               if (cnt_ff != '0) begin
                  acc_ff <= acc_ff + 64'(sq_ff);
               end
               if (cnt_ff == 5'd3) begin
                  s_ff     <= acc_ff + 64'(sq_ff);
                  rem_ff   <= '0;
                  root_ff  <= '0;
                  cnt_ff   <= '0;
                  state_ff <= N_SQRT;
               end else begin
                  cnt_ff <= cnt_ff + 1'b1;
               end
            end
            N_SQRT: begin
               s_ff <= s_ff << 2;
               if (rem_try >= trial) begin
                  rem_ff  <= rem_try - trial;
                  root_ff <= {root_ff[30:0], 1'b1};
               end else begin
                  rem_ff  <= rem_try;
                  root_ff <= {root_ff[30:0], 1'b0};
               end
               if (cnt_ff == 5'd31) begin
                  for (int c = 0; c < 3; c++) begin
                     drem_ff[c] <= 32'(u_ff[c][30:1]);
                     lo_ff[c]   <= {u_ff[c][0], 30'd0};
                     q_ff[c]    <= '0;
                  end
                  cnt_ff   <= '0;
                  state_ff <= N_DIV;
               end else begin
                  cnt_ff <= cnt_ff + 1'b1;
               end
            end
            N_DIV: begin
               for (int c = 0; c < 3; c++) begin
                  drem_ff[c] <= drem_in[c];
                  lo_ff[c]   <= lo_ff[c] << 1;
                  q_ff[c]    <= q_in[c];
               end
               if (cnt_ff == 5'd30) begin
                  out_ff.x <= neg_ff[0] ? -$signed({1'b0, q_in[0]}) : $signed({1'b0, q_in[0]});
                  out_ff.y <= neg_ff[1] ? -$signed({1'b0, q_in[1]}) : $signed({1'b0, q_in[1]});
                  out_ff.z <= neg_ff[2] ? -$signed({1'b0, q_in[2]}) : $signed({1'b0, q_in[2]});
                  nz_ff    <= 1'b1;
                  state_ff <= N_IDLE;
               end else begin
                  cnt_ff <= cnt_ff + 1'b1;
               end
            end
            default: state_ff <= N_IDLE;
         endcase
      end
   end

   assign vec_out      = out_ff;
   assign stat.done    = done_ff;
   assign stat.nonzero = nz_ff;

endmodule

[rtl/stvg_back.sv]
// Back end of the stream tube vertex generator: frame sequencer around one
// shared multiplier and stvg_norm, ring vertex emission and the result register.

module stvg_back #(
   parameter int TESSELATION = stvg_pkg::TESSELATION_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic [30:0]       radius,
   input  logic              q_empty,
   output logic              q_pop,
   input  stvg_pkg::job_type q_data,
   input  logic              pop,
   output logic              empty,
   output stvg_pkg::rsp_type rsp_data
);

   localparam int IW = $clog2(TESSELATION);
   localparam logic [IW-1:0] LAST_I = IW'(TESSELATION - 1);

   localparam logic [3:0] B_IDLE     = 4'd0;
   localparam logic [3:0] B_TAN_GO   = 4'd1;
   localparam logic [3:0] B_TAN_WAIT = 4'd2;
   localparam logic [3:0] B_BIN_GO   = 4'd3;
   localparam logic [3:0] B_BIN_WAIT = 4'd4;
   localparam logic [3:0] B_CRS      = 4'd5;
   localparam logic [3:0] B_NRM_GO   = 4'd6;
   localparam logic [3:0] B_NRM_WAIT = 4'd7;
   localparam logic [3:0] B_VTX      = 4'd8;

   localparam logic [3:0] CRS_LAST = 4'd6;
   localparam logic [3:0] VTX_OUT  = 4'd9;

   logic signed [31:0] cos_tab [TESSELATION];
   logic signed [31:0] sin_tab [TESSELATION];

   for (genvar g = 0; g < TESSELATION; g++) begin : g_trig
      localparam longint unsigned QD = (4 * g) / TESSELATION;
      localparam longint unsigned RM = 4 * g - QD * TESSELATION;
      localparam longint unsigned QM = QD % 4;
      localparam logic [63:0] BA = (stvg_pkg::PI_HALF_Q30 * RM) / TESSELATION;
      localparam logic [63:0] CS = stvg_pkg::taylor_cs(BA);
      localparam logic signed [31:0] CV = CS[63:32];
      localparam logic signed [31:0] SV = CS[31:0];
      localparam logic signed [31:0] COSQ =
         (QM == 0) ? CV : (QM == 1) ? -SV : (QM == 2) ? -CV : SV;
      localparam logic signed [31:0] SINQ =
         (QM == 0) ? SV : (QM == 1) ? CV : (QM == 2) ? -SV : -CV;
      assign cos_tab[g] = COSQ;
      assign sin_tab[g] = SINQ;
   end

   logic [3:0]          state_ff;
   logic [3:0]          step_ff;
   logic [IW-1:0]       idx_ff;
   stvg_pkg::job_type   job_ff;
   logic signed [31:0]  tan_ff [3];
   logic signed [31:0]  bin_ff [3];
   logic signed [31:0]  nrm_ff [3];
   logic signed [62:0]  crs_ff [3];
   logic signed [31:0]  lx_ff;
   logic signed [31:0]  ly_ff;
   logic signed [33:0]  acc_ff [3];
   logic [63:0]         prod_ff;
   logic                pneg_ff;
   logic                out_valid_ff;
   stvg_pkg::rsp_type   out_ff;

   logic signed [32:0]  opa;
   logic signed [32:0]  opb;
   logic [32:0]         ma;
   logic [32:0]         mb;
   logic signed [63:0]  pf;
   logic signed [63:0]  pq;
   logic signed [33:0]  pq34;
   logic signed [32:0]  tan2_mag;
   logic signed [33:0]  helper_gap;
   logic                norm_start;
   stvg_pkg::norm_in_type   norm_in;
   stvg_pkg::norm_out_type  norm_out;
   stvg_pkg::norm_stat_type norm_stat;
   stvg_pkg::rsp_type   vtx;
   logic [IW-1:0]       idx_next;
   logic                out_free;
   logic                out_load;

   function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
      if (v > 34'sd2147483647) begin
         return 32'sh7fff_ffff;
      end else if (v < -34'sd2147483648) begin
         return 32'sh8000_0000;
      end
      return 32'(v);
   endfunction

   stvg_norm u_norm (
      .clock   (clock),
      .reset   (reset),
      .start   (norm_start),
      .vec_in  (norm_in),
      .vec_out (norm_out),
      .stat    (norm_stat)
   );

   always_comb begin
      tan2_mag   = tan_ff[2] < 0 ? -33'(tan_ff[2]) : 33'(tan_ff[2]);
      helper_gap = 34'(stvg_pkg::ONE_Q30) - 34'(tan2_mag);
      norm_start = (state_ff == B_TAN_GO) || (state_ff == B_BIN_GO)
                   || (state_ff == B_NRM_GO);
      norm_in = '0;
      unique case (state_ff)
         B_TAN_GO: begin
            norm_in.x = 63'(job_ff.req.vel_x);
            norm_in.y = 63'(job_ff.req.vel_y);
            norm_in.z = 63'(job_ff.req.vel_z);
         end
         B_BIN_GO: begin
            if (helper_gap <= stvg_pkg::HELPER_EPS) begin
               norm_in.x = 63'(tan_ff[2]);
               norm_in.z = -63'(tan_ff[0]);
            end else begin
               norm_in.x = -63'(tan_ff[1]);
               norm_in.y = 63'(tan_ff[0]);
            end
         end
         B_NRM_GO: begin
            norm_in.x = crs_ff[0];
            norm_in.y = crs_ff[1];
            norm_in.z = crs_ff[2];
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      opa = '0;
      opb = '0;
      if (state_ff == B_CRS) begin
         unique case (step_ff)
            4'd0: begin opa = 33'(tan_ff[1]); opb = 33'(bin_ff[2]); end
            4'd1: begin opa = 33'(tan_ff[2]); opb = 33'(bin_ff[1]); end
            4'd2: begin opa = 33'(tan_ff[2]); opb = 33'(bin_ff[0]); end
            4'd3: begin opa = 33'(tan_ff[0]); opb = 33'(bin_ff[2]); end
            4'd4: begin opa = 33'(tan_ff[0]); opb = 33'(bin_ff[1]); end
            4'd5: begin opa = 33'(tan_ff[1]); opb = 33'(bin_ff[0]); end
            default: begin
            end
         endcase
      end else if (state_ff == B_VTX) begin
         unique case (step_ff)
            4'd0: begin opa = {2'b00, radius}; opb = 33'(cos_tab[idx_ff]); end
            4'd1: begin opa = {2'b00, radius}; opb = 33'(sin_tab[idx_ff]); end
            4'd2: begin opa = 33'(nrm_ff[0]); opb = 33'(lx_ff); end
            4'd3: begin opa = 33'(bin_ff[0]); opb = 33'(ly_ff); end
            4'd4: begin opa = 33'(nrm_ff[1]); opb = 33'(lx_ff); end
            4'd5: begin opa = 33'(bin_ff[1]); opb = 33'(ly_ff); end
            4'd6: begin opa = 33'(nrm_ff[2]); opb = 33'(lx_ff); end
            4'd7: begin opa = 33'(bin_ff[2]); opb = 33'(ly_ff); end
            default: begin
            end
         endcase
      end
      ma = opa < 0 ? 33'(-opa) : 33'(opa);
      mb = opb < 0 ? 33'(-opb) : 33'(opb);
   end

   always_ff @(posedge clock) begin
      prod_ff <= 64'(ma[31:0]) * 64'(mb[31:0]);
      pneg_ff <= (opa < 0) != (opb < 0);
   end

   always_comb begin
      pf   = pneg_ff ? -$signed(prod_ff) : $signed(prod_ff);
      pq   = pneg_ff ? -$signed(prod_ff >> 30) : $signed(prod_ff >> 30);
      pq34 = 34'(pq);
      idx_next = (idx_ff == LAST_I) ? '0 : idx_ff + 1'b1;
      vtx.vert_x  = sat32(acc_ff[0]);
      vtx.vert_y  = sat32(acc_ff[1]);
      vtx.vert_z  = sat32(acc_ff[2]);
      vtx.color_r = job_ff.req.vel_x;
      vtx.color_g = job_ff.req.vel_y;
      vtx.color_b = job_ff.req.vel_z;
      if (job_ff.req.last_sample) begin
         vtx.quad_index_a = '0;
         vtx.quad_index_b = '0;
         vtx.quad_valid   = 1'b0;
      end else begin
         vtx.quad_index_a = job_ff.base + 16'(idx_ff);
         vtx.quad_index_b = job_ff.base + 16'(idx_next);
         vtx.quad_valid   = 1'b1;
      end
      vtx.ring_end = idx_ff == LAST_I;
      out_free = !out_valid_ff || pop;
      out_load = (state_ff == B_VTX) && (step_ff == VTX_OUT) && out_free;
   end

   assign q_pop = (state_ff == B_IDLE) && !q_empty;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_IDLE;
         step_ff      <= '0;
         idx_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         if (pop && out_valid_ff && !out_load) begin
            out_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            B_IDLE: begin
               if (!q_empty) begin
                  job_ff   <= q_data;
                  state_ff <= B_TAN_GO;
               end
            end
            B_TAN_GO: state_ff <= B_TAN_WAIT;
            B_TAN_WAIT: begin
               if (norm_stat.done) begin
                  if (norm_stat.nonzero) begin
                     tan_ff[0] <= norm_out.x;
                     tan_ff[1] <= norm_out.y;
                     tan_ff[2] <= norm_out.z;
                  end else begin
                     tan_ff[0] <= '0;
                     tan_ff[1] <= '0;
                     tan_ff[2] <= stvg_pkg::ONE_Q30;
                  end
                  state_ff <= B_BIN_GO;
               end
            end
            B_BIN_GO: state_ff <= B_BIN_WAIT;
            B_BIN_WAIT: begin
               if (norm_stat.done) begin
                  bin_ff[0] <= norm_out.x;
                  bin_ff[1] <= norm_out.y;
                  bin_ff[2] <= norm_out.z;
                  step_ff   <= '0;
                  state_ff  <= B_CRS;
               end
            end
            B_CRS: begin
               unique case (step_ff)
                  4'd1: crs_ff[0] <= 63'(pf);
                  4'd2: crs_ff[0] <= 63'(64'(crs_ff[0]) - pf);
                  4'd3: crs_ff[1] <= 63'(pf);
                  4'd4: crs_ff[1] <= 63'(64'(crs_ff[1]) - pf);
                  4'd5: crs_ff[2] <= 63'(pf);
                  4'd6: crs_ff[2] <= 63'(64'(crs_ff[2]) - pf);
                  default: begin
                  end
               endcase
               if (step_ff == CRS_LAST) begin
                  state_ff <= B_NRM_GO;
               end else begin
                  step_ff <= step_ff + 1'b1;
               end
            end
            B_NRM_GO: state_ff <= B_NRM_WAIT;
            B_NRM_WAIT: begin
               if (norm_stat.done) begin
                  nrm_ff[0] <= norm_out.x;
                  nrm_ff[1] <= norm_out.y;
                  nrm_ff[2] <= norm_out.z;
                  step_ff   <= '0;
                  idx_ff    <= '0;
                  state_ff  <= B_VTX;
               end
            end
            B_VTX: begin
               unique case (step_ff)
                  4'd1: lx_ff <= 32'(pq);
                  4'd2: ly_ff <= 32'(pq);
                  4'd3: acc_ff[0] <= 34'(job_ff.req.pos_x) + pq34;
                  4'd4: acc_ff[0] <= acc_ff[0] + pq34;
                  4'd5: acc_ff[1] <= 34'(job_ff.req.pos_y) + pq34;
                  4'd6: acc_ff[1] <= acc_ff[1] + pq34;
                  4'd7: acc_ff[2] <= 34'(job_ff.req.pos_z) + pq34;
                  4'd8: acc_ff[2] <= acc_ff[2] + pq34;
                  default: begin
                  end
               endcase
               if (step_ff != VTX_OUT) begin
                  step_ff <= step_ff + 1'b1;
               end else if (out_free) begin
                  out_ff       <= vtx;
                  out_valid_ff <= 1'b1;
                  step_ff      <= '0;
                  if (idx_ff == LAST_I) begin
                     state_ff <= B_IDLE;
                  end else begin
                     idx_ff <= idx_next;
                  end
               end
            end
            default: state_ff <= B_IDLE;
         endcase
      end
   end

   assign empty    = !out_valid_ff;
   assign rsp_data = out_ff;

endmodule
